### rtl/core/dsil_pkg.sv
package dsil_pkg;

	// default sizes
	localparam int DEPTH_DEF    = 32;
	localparam int KEY_BITS_DEF = 32;

	// opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DUMP   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	// request beat
	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] key_value;
	} req_t;

	// response beat
	typedef struct packed {
		logic signed [31:0] entry_value;
		logic [4:0]         entry_position;
		logic               last_flag;
		logic [1:0]         status_code;
		logic [5:0]         entry_count;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rot;
	} cell_ctl_t;

endpackage

### rtl/core/descending_sorted_insert_list_top.sv
// insert, clear and empty dump give one response beat, valid in the cycle after the request is accepted
// a dump of n keys gives n beats, one per cycle while the response side does not stall
// one request per cycle, except while a dump is sending its beats
// a stalled response beat holds the request side as well
// reset clears the fill count, dump state and response valid; cell keys are not reset
module descending_sorted_insert_list_top #(
	parameter int DEPTH    = dsil_pkg::DEPTH_DEF,
	parameter int KEY_BITS = dsil_pkg::KEY_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dsil_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dsil_pkg::rsp_t rsp
);
	import dsil_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]              count_q;
	logic                       busy_q;
	logic [PW-1:0]              idx_q;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;

	logic                       slot_free;
	logic                       accept;
	logic signed [KEY_BITS-1:0] new_key;
	logic signed [KEY_BITS-1:0] keys [DEPTH];
	logic [DEPTH-1:0]           gts;
	logic [DEPTH-1:0]           bnd;
	logic [PW-1:0]              pos;
	logic                       full;
	logic                       dump_last;
	cell_ctl_t                  ctl;

	// handshake
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy_q || !slot_free;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign new_key   = KEY_BITS'(req.key_value);
	assign full      = count_q == CW'(DEPTH);
	assign dump_last = (CW'(idx_q) + CW'(1)) == count_q;

	// cell commands
	assign ctl.ins = accept && (req.opcode == OP_INSERT);
	assign ctl.rot = busy_q && slot_free;

	// chain of compare and shift cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_BITS-1:0] lk;
		logic                       lg;
		logic signed [KEY_BITS-1:0] rk;
		if (i == 0) begin : g_first
			assign lk = new_key;
			assign lg = 1'b1;
		end else begin : g_mid
			assign lk = keys[i-1];
			assign lg = gts[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rk = keys[i];
		end else begin : g_inner
			assign rk = keys[i+1];
		end
		dsil_cell #(
			.KEY_BITS(KEY_BITS),
			.CW      (CW),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.new_key  (new_key),
			.left_key (lk),
			.left_gt  (lg),
			.right_key(rk),
			.head_key (keys[0]),
			.count    (count_q),
			.key      (keys[i]),
			.gt       (gts[i]),
			.boundary (bnd[i])
		);
	end

	// one-hot boundary to insert position, zero when the list is full and every key is greater
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bnd[i]) begin
				pos = pos | PW'(i);
			end
		end
	end

	// fill count and dump sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else if (accept) begin
			case (req.opcode)
				OP_INSERT: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				OP_DUMP: begin
					busy_q <= count_q != '0;
					idx_q  <= '0;
				end
				OP_CLEAR: begin
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (ctl.rot) begin
			idx_q <= idx_q + PW'(1);
			if (dump_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= busy_q || (accept && (req.opcode == OP_INSERT ||
				req.opcode == OP_CLEAR || (req.opcode == OP_DUMP && count_q == '0)));
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			rsp_q.entry_value    <= 32'(keys[0]);
			rsp_q.entry_position <= 5'(idx_q);
			rsp_q.last_flag      <= dump_last;
			rsp_q.status_code    <= ST_OK;
			rsp_q.entry_count    <= 6'(count_q);
		end else if (accept) begin
			rsp_q.last_flag <= 1'b1;
			case (req.opcode)
				OP_INSERT: begin
					rsp_q.entry_value    <= 32'(new_key);
					rsp_q.entry_position <= 5'(pos);
					rsp_q.status_code    <= full ? ST_OVERFLOW : ST_OK;
					rsp_q.entry_count    <= full ? 6'(count_q) : 6'(count_q + CW'(1));
				end
				OP_DUMP: begin
					rsp_q.entry_value    <= '0;
					rsp_q.entry_position <= '0;
					rsp_q.status_code    <= ST_EMPTY;
					rsp_q.entry_count    <= '0;
				end
				default: begin
					rsp_q.entry_value    <= '0;
					rsp_q.entry_position <= '0;
					rsp_q.status_code    <= ST_OK;
					rsp_q.entry_count    <= '0;
				end
			endcase
		end
	end

	// fill count stays within the chain
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// a dump never runs on an empty list
	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> count_q != '0)
		else $error("dump active with empty list");

	// a clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.opcode == OP_CLEAR |=> count_q == '0 && rsp_valid_q)
		else $error("clear did not empty the list");

	// the dump ends with a last beat
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> rsp_valid_q && rsp_q.last_flag)
		else $error("dump ended without last beat");

endmodule

### rtl/core/dsil_cell.sv
module dsil_cell #(
	parameter int KEY_BITS = 32,
	parameter int CW       = 6,
	parameter int IDX      = 0
) (
	input  logic                       clk,
	input  dsil_pkg::cell_ctl_t        ctl,
	input  logic signed [KEY_BITS-1:0] new_key,
	input  logic signed [KEY_BITS-1:0] left_key,
	input  logic                       left_gt,
	input  logic signed [KEY_BITS-1:0] right_key,
	input  logic signed [KEY_BITS-1:0] head_key,
	input  logic [CW-1:0]              count,
	output logic signed [KEY_BITS-1:0] key,
	output logic                       gt,
	output logic                       boundary
);
	import dsil_pkg::*;

	logic signed [KEY_BITS-1:0] key_q;
	logic                       occupied;
	logic                       tail;

	// occupancy from the shared fill count
	assign occupied = CW'(IDX) < count;
	assign tail     = count == CW'(IDX + 1);

	// stored key stays ahead of the new key
	assign gt       = occupied && (key_q > new_key);
	// first cell whose key does not beat the new key
	assign boundary = !gt && left_gt;
	assign key      = key_q;

	// insert: keep, take new key, or shift from the left
	// rotate: pull from the right, tail wraps to the head
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!gt) begin
				key_q <= left_gt ? new_key : left_key;
			end
		end else if (ctl.rot) begin
			key_q <= tail ? head_key : right_key;
		end
	end

endmodule

### bench/descending_sorted_insert_list_top_tb.sv
module descending_sorted_insert_list_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsil_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int QUIET_MAX  = 5000;
	localparam int PHASE_ITEMS = 14;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// request beats waiting to be driven, response beats waiting to arrive
	req_t pending_reqs[$];
	rsp_t expected_beats[$];

	// shadow copy of the list
	logic signed [31:0] shadow_keys [DEPTH];
	int shadow_count = 0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int errors        = 0;
	int quiet_cycles  = 0;

	int n_inserts = 0, n_overflows = 0, n_dumps = 0, n_clears = 0, n_ignored = 0;
	int beats_checked = 0, deepest = 0;

	descending_sorted_insert_list_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t make_beat(logic signed [31:0] value, int pos, logic last,
		logic [1:0] status, int count);
		rsp_t b;
		b.entry_value    = value;
		b.entry_position = pos[4:0];
		b.last_flag      = last;
		b.status_code    = status;
		b.entry_count    = count[5:0];
		return b;
	endfunction

	// apply one accepted request to the shadow list and queue its response beats
	function automatic void predict_list(input req_t r);
		logic signed [31:0] k;
		logic [1:0] status;
		int pos;
		k = r.key_value;
		case (r.opcode)
			OP_INSERT: begin
				n_inserts++;
				pos = 0;
				while (pos < shadow_count && shadow_keys[pos] > k)
					pos++;
				if (shadow_count < DEPTH) begin
					for (int i = shadow_count; i > pos; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[pos] = k;
					shadow_count++;
					status = ST_OK;
				end else begin
					// full: drop the smallest, or the new key if every key is greater
					status = ST_OVERFLOW;
					n_overflows++;
					if (pos < DEPTH) begin
						for (int i = DEPTH - 1; i > pos; i--)
							shadow_keys[i] = shadow_keys[i-1];
						shadow_keys[pos] = k;
					end else begin
						pos = 0;
					end
				end
				if (shadow_count > deepest)
					deepest = shadow_count;
				expected_beats.push_back(make_beat(k, pos, 1'b1, status, shadow_count));
			end
			OP_DUMP: begin
				n_dumps++;
				if (shadow_count == 0) begin
					expected_beats.push_back(make_beat('0, 0, 1'b1, ST_EMPTY, 0));
				end else begin
					for (int i = 0; i < shadow_count; i++)
						expected_beats.push_back(make_beat(shadow_keys[i], i,
							i == shadow_count - 1, ST_OK, shadow_count));
				end
			end
			OP_CLEAR: begin
				n_clears++;
				shadow_count = 0;
				expected_beats.push_back(make_beat('0, 0, 1'b1, ST_OK, 0));
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic void check_beat(input rsp_t got);
		rsp_t want;
		bit bad;
		if (expected_beats.size() == 0) begin
			errors++;
			$display("%0t: unexpected beat: value %0d pos %0d last %0d status %0d count %0d",
				$time, got.entry_value, got.entry_position, got.last_flag, got.status_code,
				got.entry_count);
			return;
		end
		want = expected_beats.pop_front();
		beats_checked++;
		bad = (got.entry_value !== want.entry_value) ||
			(got.entry_position !== want.entry_position) ||
			(got.last_flag !== want.last_flag) ||
			(got.status_code !== want.status_code) ||
			(got.entry_count !== want.entry_count);
		if (bad) begin
			errors++;
			$display("%0t: mismatch, expected value %0d pos %0d last %0d status %0d count %0d",
				$time, want.entry_value, want.entry_position, want.last_flag, want.status_code,
				want.entry_count);
			$display("%0t:           actual   value %0d pos %0d last %0d status %0d count %0d",
				$time, got.entry_value, got.entry_position, got.last_flag, got.status_code,
				got.entry_count);
		end
	endfunction

	// driver: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall)
				predict_list(req);
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check accepted response beats, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_beat(rsp);
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("watchdog: no progress for %0d cycles", quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic void push_req(logic [1:0] op, logic [31:0] key);
		req_t r;
		r.opcode    = op;
		r.key_value = key;
		pending_reqs.push_back(r);
	endfunction

	// mix of extremes, a small pool of whole numbers for ties, and full range
	function automatic logic [31:0] random_key();
		int sel;
		int whole;
		sel = $urandom_range(9);
		case (sel)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: begin
				whole = $urandom_range(6);
				whole = whole - 3;
				return whole <<< 16;
			end
			default: return $urandom;
		endcase
	endfunction

	// bursts of inserts closed by a dump, with the odd clear and unused opcode
	task automatic fill_random_phase();
		int counted;
		int run;
		counted = 0;
		while (counted < PHASE_ITEMS) begin
			if ($urandom_range(3) == 0) begin
				push_req(OP_CLEAR, $urandom);
				counted++;
			end
			run = $urandom_range(40, 1);
			for (int i = 0; i < run; i++) begin
				if ($urandom_range(19) == 0)
					push_req(OP_UNUSED, $urandom);
				push_req(OP_INSERT, random_key());
				counted++;
			end
			push_req(OP_DUMP, $urandom);
			counted++;
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_valid || expected_beats.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, extremes, ties, unused opcode, clear
		push_req(OP_DUMP, $urandom);
		push_req(OP_CLEAR, $urandom);
		push_req(OP_INSERT, 32'h7fff_ffff);
		push_req(OP_INSERT, 32'h8000_0000);
		push_req(OP_INSERT, 32'h0000_0000);
		push_req(OP_INSERT, 32'h0000_0000);
		push_req(OP_INSERT, 32'hffff_ffff);
		push_req(OP_INSERT, 32'h0001_0000);
		push_req(OP_INSERT, 32'h7fff_ffff);
		push_req(OP_UNUSED, $urandom);
		push_req(OP_DUMP, $urandom);
		push_req(OP_CLEAR, $urandom);
		push_req(OP_DUMP, $urandom);
		push_req(OP_INSERT, 32'h8000_0000);
		push_req(OP_INSERT, 32'h8000_0000);
		push_req(OP_DUMP, $urandom);
		wait_drained();

		// random phases with different idle and stall pressure
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			fill_random_phase();
			wait_drained();
		end

		// let any stray beat show up
		stall_pct = 0;
		repeat (8) @(negedge clk);
		if (expected_beats.size() != 0)
			errors++;

		$display("covered %0d inserts (%0d on a full list), %0d dumps, %0d clears, %0d ignored",
			n_inserts, n_overflows, n_dumps, n_clears, n_ignored);
		$display("%0d response beats checked, list reached %0d keys", beats_checked, deepest);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/core/dsil_pkg.sv
rtl/core/dsil_cell.sv
rtl/core/descending_sorted_insert_list_top.sv
bench/descending_sorted_insert_list_top_tb.sv
